@@ hdl/tlpme_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpme_pkg
// Shared types and constants of the two-level page map engine.
// ----------------------------------------------------------------------------
package tlpme_pkg;

  localparam int WORD_IDX_W      = 10;
  localparam int WORDS_PER_FRAME = 1 << WORD_IDX_W;
  localparam int FLAG_W          = 12;
  localparam int FIELD_FRAME_W   = 6;
  localparam int PAGE_SHIFT      = 12;

  localparam logic [31:0] ADDR_FRAME_MASK = 32'hffff_f000;
  localparam logic [31:0] PRESENT_BIT     = 32'h0000_0001;

  typedef enum logic [1:0] {
    CMD_MAP   = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_ZERO  = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FRAME  = 2'd1,
    STATUS_BAD_FRAME = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIR_CHECK,
    S_SCAN,
    S_ZERO,
    S_WRITE_PDE,
    S_WRITE_PTE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ADDR_DIR,
    ADDR_ZERO,
    ADDR_PTE
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      mem_we;
    addr_sel_t addr_sel;
    logic      scan_inc;
    logic      scan_take;
    logic      mark_target;
    logic      table_from_de;
    logic      table_from_target;
    logic      res_load;
    status_t   res_status;
    logic      res_alloc;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic dir_ok;
    logic tgt_ok;
    logic de_present;
    logic de_ok;
    logic scan_free;
    logic scan_last;
    logic word_last;
  } dp_status_t;

endpackage

@@ hdl/tlpme_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpme_ctrl
// Sequencer: decodes the latched command and steps the datapath through
// directory lookup, frame scan, frame marking, frame zeroing and entry writes.
// ----------------------------------------------------------------------------
module tlpme_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  tlpme_pkg::dp_status_t  dp_status,
  output tlpme_pkg::ctrl_cmd_t   dp_cmd,
  output logic                   busy,
  output logic                   done
);

  tlpme_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlpme_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlpme_pkg::S_IDLE: begin
        if (start) state_next = tlpme_pkg::S_DECODE;
      end
      tlpme_pkg::S_DECODE: begin
        unique case (dp_status.cmd)
          tlpme_pkg::CMD_MAP:
            state_next = dp_status.dir_ok ? tlpme_pkg::S_DIR_CHECK : tlpme_pkg::S_DONE;
          tlpme_pkg::CMD_ALLOC:
            state_next = tlpme_pkg::S_SCAN;
          tlpme_pkg::CMD_ZERO:
            state_next = dp_status.tgt_ok ? tlpme_pkg::S_ZERO : tlpme_pkg::S_DONE;
          tlpme_pkg::CMD_MARK:
            state_next = tlpme_pkg::S_DONE;
          default:
            state_next = tlpme_pkg::S_DONE;
        endcase
      end
      tlpme_pkg::S_DIR_CHECK: begin
        priority if (!dp_status.de_present) state_next = tlpme_pkg::S_SCAN;
        else if (dp_status.de_ok)           state_next = tlpme_pkg::S_WRITE_PTE;
        else                                state_next = tlpme_pkg::S_DONE;
      end
      tlpme_pkg::S_SCAN: begin
        priority if (dp_status.scan_free) begin
          state_next = (dp_status.cmd == tlpme_pkg::CMD_ALLOC) ? tlpme_pkg::S_DONE
                                                              : tlpme_pkg::S_ZERO;
        end else if (dp_status.scan_last) begin
          state_next = tlpme_pkg::S_DONE;
        end else begin
          state_next = tlpme_pkg::S_SCAN;
        end
      end
      tlpme_pkg::S_ZERO: begin
        if (dp_status.word_last) begin
          state_next = (dp_status.cmd == tlpme_pkg::CMD_MAP) ? tlpme_pkg::S_WRITE_PDE
                                                            : tlpme_pkg::S_DONE;
        end
      end
      tlpme_pkg::S_WRITE_PDE: state_next = tlpme_pkg::S_WRITE_PTE;
      tlpme_pkg::S_WRITE_PTE: state_next = tlpme_pkg::S_DONE;
      tlpme_pkg::S_DONE:      state_next = tlpme_pkg::S_IDLE;
      default:                state_next = tlpme_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd            = '0;
    dp_cmd.addr_sel   = tlpme_pkg::ADDR_DIR;
    dp_cmd.res_status = tlpme_pkg::STATUS_OK;
    unique case (state)
      tlpme_pkg::S_IDLE: begin
        dp_cmd.load = start;
      end
      tlpme_pkg::S_DECODE: begin
        unique case (dp_status.cmd)
          tlpme_pkg::CMD_MAP: begin
            if (!dp_status.dir_ok) begin
              dp_cmd.res_load   = 1'b1;
              dp_cmd.res_status = tlpme_pkg::STATUS_BAD_FRAME;
            end
          end
          tlpme_pkg::CMD_ALLOC: ;
          tlpme_pkg::CMD_ZERO: begin
            if (dp_status.tgt_ok) begin
              dp_cmd.table_from_target = 1'b1;
            end else begin
              dp_cmd.res_load   = 1'b1;
              dp_cmd.res_status = tlpme_pkg::STATUS_BAD_FRAME;
            end
          end
          tlpme_pkg::CMD_MARK: begin
            dp_cmd.res_load = 1'b1;
            if (dp_status.tgt_ok) begin
              dp_cmd.mark_target = 1'b1;
            end else begin
              dp_cmd.res_status = tlpme_pkg::STATUS_BAD_FRAME;
            end
          end
          default: ;
        endcase
      end
      tlpme_pkg::S_DIR_CHECK: begin
        if (dp_status.de_present) begin
          if (dp_status.de_ok) begin
            dp_cmd.table_from_de = 1'b1;
          end else begin
            dp_cmd.res_load   = 1'b1;
            dp_cmd.res_status = tlpme_pkg::STATUS_BAD_FRAME;
          end
        end
      end
      tlpme_pkg::S_SCAN: begin
        priority if (dp_status.scan_free) begin
          dp_cmd.scan_take = 1'b1;
          if (dp_status.cmd == tlpme_pkg::CMD_ALLOC) begin
            dp_cmd.res_load  = 1'b1;
            dp_cmd.res_alloc = 1'b1;
          end
        end else if (dp_status.scan_last) begin
          dp_cmd.res_load   = 1'b1;
          dp_cmd.res_status = tlpme_pkg::STATUS_NO_FRAME;
        end else begin
          dp_cmd.scan_inc = 1'b1;
        end
      end
      tlpme_pkg::S_ZERO: begin
        dp_cmd.mem_we   = 1'b1;
        dp_cmd.addr_sel = tlpme_pkg::ADDR_ZERO;
        if (dp_status.word_last && dp_status.cmd != tlpme_pkg::CMD_MAP) begin
          dp_cmd.res_load = 1'b1;
        end
      end
      tlpme_pkg::S_WRITE_PDE: begin
        dp_cmd.mem_we   = 1'b1;
        dp_cmd.addr_sel = tlpme_pkg::ADDR_DIR;
      end
      tlpme_pkg::S_WRITE_PTE: begin
        dp_cmd.mem_we   = 1'b1;
        dp_cmd.addr_sel = tlpme_pkg::ADDR_PTE;
        dp_cmd.res_load = 1'b1;
      end
      tlpme_pkg::S_DONE: ;
      default: ;
    endcase
  end

  assign busy = (state != tlpme_pkg::S_IDLE);
  assign done = (state == tlpme_pkg::S_DONE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("transaction accepted but engine not busy");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("engine still busy after result strobe");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.mem_we |-> (busy && !done))
    else $error("table store written outside a transaction");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.res_load |=> !dp_cmd.res_load)
    else $error("result loaded twice for one transaction");

endmodule

@@ hdl/tlpme_datapath.sv @@
// ----------------------------------------------------------------------------
// tlpme_datapath
// Command registers, frame bitmap with scan counter, zeroing counter,
// table store and result registers.
// ----------------------------------------------------------------------------
module tlpme_datapath #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tlpme_pkg::ctrl_cmd_t                 dp_cmd,
  output tlpme_pkg::dp_status_t                dp_status,
  input  logic [1:0]                           cmd,
  input  logic [tlpme_pkg::FIELD_FRAME_W-1:0]  dir_frame,
  input  logic [31:0]                          virt_addr,
  input  logic [31:0]                          phys_addr,
  input  logic [tlpme_pkg::FLAG_W-1:0]         page_flags,
  input  logic [tlpme_pkg::FIELD_FRAME_W-1:0]  target_frame,
  output logic [1:0]                           status,
  output logic [tlpme_pkg::FIELD_FRAME_W-1:0]  frame_number,
  output logic                                 new_table
);

  localparam int FW     = $clog2(NUM_FRAMES);
  localparam int AW     = FW + tlpme_pkg::WORD_IDX_W;
  localparam int DEPTH  = NUM_FRAMES * tlpme_pkg::WORDS_PER_FRAME;
  localparam int FFW    = tlpme_pkg::FIELD_FRAME_W;
  localparam int IW     = tlpme_pkg::WORD_IDX_W;

  tlpme_pkg::cmd_t              latched_cmd;
  logic [FFW-1:0]               latched_dir;
  logic [FFW-1:0]               latched_tgt;
  logic [IW-1:0]                dir_idx;
  logic [IW-1:0]                tbl_idx;
  logic [31:0]                  latched_pa;
  logic [tlpme_pkg::FLAG_W-1:0] latched_flags;

  logic [NUM_FRAMES-1:0] used_map;
  logic [FW-1:0]         scan_idx;
  logic [IW-1:0]         word_cnt;
  logic [FW-1:0]         table_frame;
  logic                  fresh;

  logic [31:0] mem [0:DEPTH-1];
  logic [31:0] rdata;
  logic [AW-1:0] addr;
  logic [31:0] wdata;

  logic [31:0] dir_ext, tgt_ext, table_ext, scan_ext, de_frame_ext;
  logic [FW-1:0] dir_fr, tgt_fr;

  assign dir_ext      = 32'(latched_dir);
  assign tgt_ext      = 32'(latched_tgt);
  assign table_ext    = 32'(table_frame);
  assign scan_ext     = 32'(scan_idx);
  assign de_frame_ext = {12'd0, rdata[31:tlpme_pkg::PAGE_SHIFT]};
  assign dir_fr       = dir_ext[FW-1:0];
  assign tgt_fr       = tgt_ext[FW-1:0];

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      latched_cmd   <= tlpme_pkg::cmd_t'(cmd);
      latched_dir   <= dir_frame;
      latched_tgt   <= target_frame;
      dir_idx       <= virt_addr[31:22];
      tbl_idx       <= virt_addr[21:12];
      latched_pa    <= phys_addr;
      latched_flags <= page_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
    end else if (dp_cmd.scan_take) begin
      used_map[scan_idx] <= 1'b1;
    end else if (dp_cmd.mark_target) begin
      used_map[tgt_fr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      word_cnt <= '0;
      fresh    <= 1'b0;
    end else begin
      if (dp_cmd.load) begin
        scan_idx <= '0;
        word_cnt <= '0;
        fresh    <= 1'b0;
      end else begin
        if (dp_cmd.scan_inc) scan_idx <= scan_idx + 1'b1;
        if (dp_cmd.scan_take) fresh <= 1'b1;
        if (dp_cmd.mem_we && dp_cmd.addr_sel == tlpme_pkg::ADDR_ZERO) begin
          word_cnt <= word_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.scan_take) begin
      table_frame <= scan_idx;
    end else if (dp_cmd.table_from_de) begin
      table_frame <= de_frame_ext[FW-1:0];
    end else if (dp_cmd.table_from_target) begin
      table_frame <= tgt_fr;
    end
  end

  always_comb begin
    unique case (dp_cmd.addr_sel)
      tlpme_pkg::ADDR_DIR: begin
        addr  = {dir_fr, dir_idx};
        wdata = ((table_ext << tlpme_pkg::PAGE_SHIFT) & tlpme_pkg::ADDR_FRAME_MASK)
                | 32'(latched_flags) | tlpme_pkg::PRESENT_BIT;
      end
      tlpme_pkg::ADDR_ZERO: begin
        addr  = {table_frame, word_cnt};
        wdata = '0;
      end
      tlpme_pkg::ADDR_PTE: begin
        addr  = {table_frame, tbl_idx};
        wdata = (latched_pa & tlpme_pkg::ADDR_FRAME_MASK)
                | 32'(latched_flags) | tlpme_pkg::PRESENT_BIT;
      end
      default: begin
        addr  = {dir_fr, dir_idx};
        wdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.mem_we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.res_load) begin
      status <= dp_cmd.res_status;
      if (dp_cmd.res_alloc) begin
        frame_number <= scan_ext[FFW-1:0];
        new_table    <= 1'b0;
      end else begin
        frame_number <= fresh ? table_ext[FFW-1:0] : '0;
        new_table    <= fresh;
      end
    end
  end

  assign dp_status.cmd        = latched_cmd;
  assign dp_status.dir_ok     = dir_ext < 32'(NUM_FRAMES);
  assign dp_status.tgt_ok     = tgt_ext < 32'(NUM_FRAMES);
  assign dp_status.de_present = rdata[0];
  assign dp_status.de_ok      = de_frame_ext < 32'(NUM_FRAMES);
  assign dp_status.scan_free  = !used_map[scan_idx];
  assign dp_status.scan_last  = scan_idx == FW'(NUM_FRAMES - 1);
  assign dp_status.word_last  = &word_cnt;

endmodule

@@ hdl/two_level_page_map_engine_unit.sv @@
// ----------------------------------------------------------------------------
// two_level_page_map_engine_unit
// Frame allocator and two-level page table writer over a store of table frames.
// ----------------------------------------------------------------------------
// Alloc and map with a new table scan the bitmap from frame 0 up to k, the
//   lowest free frame index (bitmap scanned one frame per cycle); zero frame
//   writes one store word per cycle.
// One transaction at a time; the next start is taken the cycle after done.
// Synchronous reset marks every frame free; table store contents undefined.
// ----------------------------------------------------------------------------
module two_level_page_map_engine_unit #(
  parameter int NUM_FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [5:0]  dir_frame,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [11:0] page_flags,
  input  logic [5:0]  target_frame,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  frame_number,
  output logic        new_table
);

  tlpme_pkg::ctrl_cmd_t  dp_cmd;
  tlpme_pkg::dp_status_t dp_status;

  tlpme_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .busy      (busy),
    .done      (done)
  );

  tlpme_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .dp_status    (dp_status),
    .cmd          (cmd),
    .dir_frame    (dir_frame),
    .virt_addr    (virt_addr),
    .phys_addr    (phys_addr),
    .page_flags   (page_flags),
    .target_frame (target_frame),
    .status       (status),
    .frame_number (frame_number),
    .new_table    (new_table)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for two_level_page_map_engine_unit. A directed table
// and three random phases drive map, alloc, zero and mark commands. Each
// result is checked against a given expected result or against an in-bench
// model of the frame bitmap and the table store. Maps only read directory
// frames that have been cleared since reset.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAMES       = 64;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int WPF          = tlpme_pkg::WORDS_PER_FRAME;

  typedef struct packed {
    tlpme_pkg::cmd_t cmd;
    logic [5:0]      dir_frame;
    logic [31:0]     virt_addr;
    logic [31:0]     phys_addr;
    logic [11:0]     page_flags;
    logic [5:0]      target_frame;
  } page_req_t;

  typedef struct packed {
    tlpme_pkg::status_t status;
    logic [5:0]         frame_number;
    logic               new_table;
  } page_res_t;

  typedef struct packed {
    page_req_t req;
    logic      typed;
    page_res_t res;
  } plan_row_t;

  localparam page_res_t RES_NONE = '0;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  cmd;
  logic [5:0]  dir_frame;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [11:0] page_flags;
  logic [5:0]  target_frame;
  logic        done;
  logic [1:0]  status;
  logic [5:0]  frame_number;
  logic        new_table;

  logic [31:0] table_words [FRAMES*WPF];
  bit          frame_taken [FRAMES];
  bit          frame_clean [FRAMES];

  page_res_t   pending_results [$];
  plan_row_t   plan [$];
  int          mismatch_cnt    = 0;
  int          result_idx      = 0;
  int          cycle_cnt       = 0;
  int          sender_idle_pct = 0;

  two_level_page_map_engine_unit #(.NUM_FRAMES(FRAMES)) dut (.*);

  always #2 clk = ~clk;

  function automatic int word_index(input int frame, input logic [9:0] idx);
    return frame * WPF + int'(idx);
  endfunction

  function automatic int take_lowest_frame();
    for (int f = 0; f < FRAMES; f++) begin
      if (!frame_taken[f]) begin
        frame_taken[f] = 1'b1;
        return f;
      end
    end
    return FRAMES;
  endfunction

  function automatic void clear_frame(input int frame);
    for (int i = 0; i < WPF; i++) table_words[frame*WPF + i] = '0;
    frame_clean[frame] = 1'b1;
  endfunction

  function automatic page_res_t apply_page_cmd(input page_req_t r);
    page_res_t   res;
    logic [9:0]  di;
    logic [9:0]  ti;
    logic [31:0] de;
    int          tf;
    res.status       = tlpme_pkg::STATUS_OK;
    res.frame_number = '0;
    res.new_table    = 1'b0;
    di = r.virt_addr[31:22];
    ti = r.virt_addr[21:12];
    tf = 0;
    case (r.cmd)
      tlpme_pkg::CMD_MAP: begin
        if (int'(r.dir_frame) >= FRAMES) begin
          res.status = tlpme_pkg::STATUS_BAD_FRAME;
        end else begin
          de = table_words[word_index(int'(r.dir_frame), di)];
          if (de[0]) begin
            tf = int'(de[31:12]);
            if (tf >= FRAMES) res.status = tlpme_pkg::STATUS_BAD_FRAME;
          end else begin
            tf = take_lowest_frame();
            if (tf >= FRAMES) begin
              res.status = tlpme_pkg::STATUS_NO_FRAME;
            end else begin
              // fresh table may be the directory frame itself: clear first
              clear_frame(tf);
              table_words[word_index(int'(r.dir_frame), di)] =
                ((32'(tf) << tlpme_pkg::PAGE_SHIFT) & tlpme_pkg::ADDR_FRAME_MASK)
                | {20'd0, r.page_flags} | tlpme_pkg::PRESENT_BIT;
              res.frame_number = 6'(tf);
              res.new_table    = 1'b1;
            end
          end
          if (res.status == tlpme_pkg::STATUS_OK)
            table_words[word_index(tf, ti)] =
              (r.phys_addr & tlpme_pkg::ADDR_FRAME_MASK) | {20'd0, r.page_flags}
              | tlpme_pkg::PRESENT_BIT;
        end
      end
      tlpme_pkg::CMD_ALLOC: begin
        tf = take_lowest_frame();
        if (tf >= FRAMES) res.status = tlpme_pkg::STATUS_NO_FRAME;
        else res.frame_number = 6'(tf);
      end
      tlpme_pkg::CMD_ZERO: begin
        if (int'(r.target_frame) >= FRAMES) res.status = tlpme_pkg::STATUS_BAD_FRAME;
        else clear_frame(int'(r.target_frame));
      end
      default: begin
        if (int'(r.target_frame) >= FRAMES) res.status = tlpme_pkg::STATUS_BAD_FRAME;
        else frame_taken[r.target_frame] = 1'b1;
      end
    endcase
    return res;
  endfunction

  function automatic page_req_t make_req(input tlpme_pkg::cmd_t c, input logic [5:0] dirf,
                                         input logic [31:0] va, input logic [31:0] pa,
                                         input logic [11:0] flags, input logic [5:0] tgt);
    page_req_t r;
    r.cmd          = c;
    r.dir_frame    = dirf;
    r.virt_addr    = va;
    r.phys_addr    = pa;
    r.page_flags   = flags;
    r.target_frame = tgt;
    return r;
  endfunction

  function automatic page_res_t make_res(input tlpme_pkg::status_t st,
                                         input logic [5:0] fnum, input logic fresh);
    page_res_t res;
    res.status       = st;
    res.frame_number = fnum;
    res.new_table    = fresh;
    return res;
  endfunction

  function automatic int pick_clean_frame();
    int pool [$];
    for (int f = 0; f < FRAMES; f++) if (frame_clean[f]) pool.push_back(f);
    if (pool.size() == 0) return -1;
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // Maps go to cleared directories only; directory indexes cluster so that
  // later maps land on present entries.
  function automatic page_req_t rand_page_req();
    page_req_t       r;
    int              sel;
    int              dirf;
    tlpme_pkg::cmd_t c;
    sel  = $urandom_range(0, 99);
    dirf = pick_clean_frame();
    c = sel < 55 ? tlpme_pkg::CMD_MAP : sel < 65 ? tlpme_pkg::CMD_ALLOC :
        sel < 80 ? tlpme_pkg::CMD_ZERO : tlpme_pkg::CMD_MARK;
    r = make_req(c, 6'($urandom), $urandom, $urandom, 12'($urandom), 6'($urandom));
    if (r.cmd == tlpme_pkg::CMD_MAP) begin
      if (dirf < 0) begin
        r.cmd = tlpme_pkg::CMD_ZERO;
      end else begin
        r.dir_frame = 6'(dirf);
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 3))
            0:       r.virt_addr[31:22] = '0;
            1:       r.virt_addr[31:22] = '1;
            default: r.virt_addr[31:22] = 10'($urandom_range(1, 3));
          endcase
        end
        if ($urandom_range(0, 9) < 3) r.phys_addr[31:18] = '0;
      end
    end
    return r;
  endfunction

  task automatic issue_cmd(input page_req_t r, input logic typed, input page_res_t want);
    page_res_t pred;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= r.cmd;
    dir_frame    <= r.dir_frame;
    virt_addr    <= r.virt_addr;
    phys_addr    <= r.phys_addr;
    page_flags   <= r.page_flags;
    target_frame <= r.target_frame;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = apply_page_cmd(r);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic run_random(input int count);
    repeat (count) issue_cmd(rand_page_req(), 1'b0, RES_NONE);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] result %0d: %s got %0h expected %0h", $time, result_idx, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    page_res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, status", 32'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 32'(status), 32'(want.status));
        if (frame_number !== want.frame_number)
          report_mismatch("frame_number", 32'(frame_number), 32'(want.frame_number));
        if (new_table !== want.new_table)
          report_mismatch("new_table", 32'(new_table), 32'(want.new_table));
      end
      result_idx++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("[two_level_page_map_engine_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = tlpme_pkg::CMD_MAP;
    dir_frame    = '0;
    virt_addr    = '0;
    phys_addr    = '0;
    page_flags   = '0;
    target_frame = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directory in frame 0 takes frame 0 as its own table; the table entry
    // then overwrites the directory entry with an out-of-store frame
    plan.push_back({make_req(tlpme_pkg::CMD_ZERO, 6'd0, '0, '0, '0, 6'd0), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd0, 32'h0000_0000, 32'hffff_f000,
                             12'hfff, 6'd0),
                    1'b1, make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b1)});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd0, 32'h0000_0000, 32'h0000_0000,
                             12'h000, 6'd0),
                    1'b1, make_res(tlpme_pkg::STATUS_BAD_FRAME, 6'd0, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_ALLOC, 6'd0, '0, '0, '0, 6'd0), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd1, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_MARK, 6'd0, '0, '0, '0, 6'd63), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_ZERO, 6'd0, '0, '0, '0, 6'd63), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd63, 32'hffff_ffff, 32'hffff_ffff,
                             12'hfff, 6'd63),
                    1'b1, make_res(tlpme_pkg::STATUS_OK, 6'd2, 1'b1)});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd63, 32'hffc0_0000, 32'h0000_0000,
                             12'h000, 6'd0),
                    1'b0, RES_NONE});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd2, 32'hffc0_0000, 32'h1234_5000,
                             12'h0f0, 6'd0),
                    1'b0, RES_NONE});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd2, 32'h0000_1000, 32'h0002_a000,
                             12'h5a5, 6'd0),
                    1'b0, RES_NONE});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd63, 32'h0040_0000, 32'h0003_f000,
                             12'h001, 6'd0),
                    1'b0, RES_NONE});
    plan.push_back({make_req(tlpme_pkg::CMD_ALLOC, 6'd63, '0, '0, '0, 6'd63), 1'b0,
                    RES_NONE});
    plan.push_back({make_req(tlpme_pkg::CMD_ZERO, 6'd0, '0, '0, '0, 6'd42), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_MARK, 6'd0, '0, '0, '0, 6'd21), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd42, 32'h5555_5555, 32'haaaa_aaaa,
                             12'haaa, 6'd21),
                    1'b0, RES_NONE});
    plan.push_back({make_req(tlpme_pkg::CMD_MAP, 6'd42, 32'haaaa_aaaa, 32'h5555_5555,
                             12'h555, 6'd42),
                    1'b0, RES_NONE});
    plan.push_back({make_req(tlpme_pkg::CMD_MARK, 6'd0, '0, '0, '0, 6'd0), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0)});
    plan.push_back({make_req(tlpme_pkg::CMD_ZERO, 6'd0, '0, '0, '0, 6'd21), 1'b1,
                    make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0)});

    sender_idle_pct = 9;
    foreach (plan[i]) issue_cmd(plan[i].req, plan[i].typed, plan[i].res);
    run_random(180);
    settle();

    // use up every frame, then allocation has to fail
    for (int f = 0; f < FRAMES; f++)
      issue_cmd(make_req(tlpme_pkg::CMD_MARK, '0, '0, '0, '0, 6'(f)), 1'b1,
                make_res(tlpme_pkg::STATUS_OK, 6'd0, 1'b0));
    issue_cmd(make_req(tlpme_pkg::CMD_ALLOC, '0, '0, '0, '0, '0), 1'b1,
              make_res(tlpme_pkg::STATUS_NO_FRAME, 6'd0, 1'b0));
    issue_cmd(make_req(tlpme_pkg::CMD_MAP, 6'd63, 32'h8020_0000, 32'h0001_0000, 12'h3c3, '0),
              1'b0, RES_NONE);

    sender_idle_pct = 50;
    run_random(160);
    settle();

    sender_idle_pct = 0;
    run_random(160);
    settle();

    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("[two_level_page_map_engine_unit] OK");
    end else begin
      $display("[two_level_page_map_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/tlpme_pkg.sv
hdl/tlpme_ctrl.sv
hdl/tlpme_datapath.sv
hdl/two_level_page_map_engine_unit.sv
test/tb_top.sv
